### rtl/mof_pkg.sv
// ----------------------------------------------------------------------------
// Majority-over-third finder package
// Shared request and result types and fixed constants.
// ----------------------------------------------------------------------------
package mof_pkg;

  localparam int ValW      = 32;
  localparam int QueueDepth = 2;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] value_res;
    logic                   is_last;
    logic                   none_found;
    logic                   overflow;
  } res_item_t;

  // Head of the request queue as the engine sees it.
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } q_head_t;

endpackage

### rtl/majority_over_third_finder_unit.sv
// ----------------------------------------------------------------------------
// Majority-over-third finder
// Reports every value of a set that occurs more than floor(total/3) times.
// ----------------------------------------------------------------------------
// A request carries one signed value and a last flag; it is taken at a clock
// edge where start is high and busy is low. Requests go into a two-entry
// queue, so the port stays open while the engine counts earlier ones.
// The engine compares the value against the distinct-value table one memory
// entry per cycle: an element is first taken from the queue, then compared
// with the stored entries and written back, as a count on a match or, while
// the table has room, as a new entry. An element of a set whose item count is
// saturated is taken from the queue and ignored. On a last request the table
// is scanned again, a second result going out from a flush state, and up to
// two results go out, in order of first appearance, each held on
// res_o for one cycle with res_valid_o high. With no qualifier one result
// with none_found set goes out. The final result of a set has is_last set.
// The receiver cannot stall; results are never held back.
// Reset clears the queue and the set counters; the table memory needs no
// clearing since only entries below the distinct count are ever compared.
// ----------------------------------------------------------------------------
module majority_over_third_finder_unit #(
  parameter int              TABLE_ENTRIES = 256,
  parameter longint unsigned MAX_ITEMS     = 64'd65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mof_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output mof_pkg::res_item_t res_o
);

  mof_pkg::q_head_t head;
  logic             pop;

  mof_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start),
    .item_i (item_i),
    .full_o (busy),
    .head_o (head),
    .pop_i  (pop)
  );

  mof_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_ITEMS     (MAX_ITEMS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

### rtl/mof_queue.sv
// ----------------------------------------------------------------------------
// Majority-over-third finder request queue
// Front part: takes requests from the command port and holds them until the
// engine pops them, so the port stays open while the engine is working.
// ----------------------------------------------------------------------------
module mof_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mof_pkg::in_item_t item_i,
  output logic              full_o,
  output mof_pkg::q_head_t  head_o,
  input  logic              pop_i
);

  mof_pkg::in_item_t                    slot_q [mof_pkg::QueueDepth];
  logic                                 wr_ptr_q, rd_ptr_q;
  logic [mof_pkg::QueueCntW-1:0]        cnt_q;
  logic                                 do_push, do_pop;

  assign full_o      = (cnt_q == mof_pkg::QueueCntW'(mof_pkg::QueueDepth));
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && (cnt_q != '0);
  assign head_o.vld  = (cnt_q != '0);
  assign head_o.item = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + mof_pkg::QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - mof_pkg::QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mof_pkg::QueueCntW'(mof_pkg::QueueDepth))
    else $error("request queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.vld)
    else $error("request popped from an empty queue");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("full queue lost a request without a pop");

endmodule

### rtl/mof_engine.sv
// ----------------------------------------------------------------------------
// Majority-over-third finder engine
// Back part: counts each value in a table of distinct values held in memory,
// then scans the table at the end of a set and reports the qualifiers.
// ----------------------------------------------------------------------------
module mof_engine #(
  parameter int              TABLE_ENTRIES = 256,
  parameter longint unsigned MAX_ITEMS     = 64'd65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mof_pkg::q_head_t   head_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output mof_pkg::res_item_t res_o
);

  localparam int UW    = $clog2(TABLE_ENTRIES + 1);
  localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT,
    ST_FLUSH
  } state_e;

  state_e                        state_q;
  mof_pkg::in_item_t             item_q;
  logic [UW-1:0]                 used_q, idx_q;
  logic [CNT_W-1:0]              total_q;
  logic                          ovf_q;
  logic                          cmp_vld_q;
  logic [AW-1:0]                 cmp_idx_q;
  logic signed [mof_pkg::ValW-1:0] rd_val_q, pend_val_q;
  logic [CNT_W-1:0]              rd_cnt_q;
  logic                          pend_vld_q;
  logic                          res_vld_q;
  mof_pkg::res_item_t            res_q;

  logic signed [mof_pkg::ValW-1:0] vals_mem [TABLE_ENTRIES];
  logic [CNT_W-1:0]                cnts_mem [TABLE_ENTRIES];

  logic             issue, hit_scan, hit_rep, scan_end, table_full, at_max;
  logic [CNT_W+1:0] tri_cnt;
  logic             val_we, cnt_we;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] cnt_wdata;

  // A count exceeds floor(total/3) exactly when three times the count
  // exceeds the total, so no division is needed.
  assign tri_cnt    = {2'b00, rd_cnt_q} + {1'b0, rd_cnt_q, 1'b0};
  assign issue      = (idx_q < used_q);
  assign hit_scan   = cmp_vld_q && (rd_val_q == item_q.value);
  assign hit_rep    = cmp_vld_q && (tri_cnt > {2'b00, total_q});
  assign scan_end   = !issue && !cmp_vld_q;
  assign table_full = (used_q == UW'(TABLE_ENTRIES));
  assign at_max     = (total_q == CNT_W'(MAX_ITEMS));
  assign pop_o      = (state_q == ST_IDLE) && head_i.vld;

  always_comb begin
    val_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_addr   = used_q[AW-1:0];
    cnt_wdata = CNT_W'(1);
    if (state_q == ST_SCAN) begin
      if (hit_scan) begin
        cnt_we    = 1'b1;
        wr_addr   = cmp_idx_q;
        cnt_wdata = rd_cnt_q + CNT_W'(1);
      end else if (scan_end && !table_full) begin
        val_we = 1'b1;
        cnt_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      vals_mem[wr_addr] <= item_q.value;
    end
    if (cnt_we) begin
      cnts_mem[wr_addr] <= cnt_wdata;
    end
    rd_val_q <= vals_mem[idx_q[AW-1:0]];
    rd_cnt_q <= cnts_mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      item_q     <= '0;
      used_q     <= '0;
      idx_q      <= '0;
      total_q    <= '0;
      ovf_q      <= 1'b0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      pend_vld_q <= 1'b0;
      pend_val_q <= '0;
      res_vld_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      res_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (head_i.vld) begin
            item_q     <= head_i.item;
            idx_q      <= '0;
            cmp_vld_q  <= 1'b0;
            pend_vld_q <= 1'b0;
            if (at_max) begin
              // A saturated set ignores the element but may still end here.
              ovf_q <= 1'b1;
              if (head_i.item.last) begin
                state_q <= ST_REPORT;
              end
            end else begin
              total_q <= total_q + CNT_W'(1);
              state_q <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          cmp_vld_q <= issue;
          cmp_idx_q <= idx_q[AW-1:0];
          if (issue) begin
            idx_q <= idx_q + UW'(1);
          end
          if (hit_scan || scan_end) begin
            if (!hit_scan) begin
              if (table_full) begin
                ovf_q <= 1'b1;
              end else begin
                used_q <= used_q + UW'(1);
              end
            end
            idx_q      <= '0;
            cmp_vld_q  <= 1'b0;
            pend_vld_q <= 1'b0;
            state_q    <= item_q.last ? ST_REPORT : ST_IDLE;
          end
        end

        ST_REPORT: begin
          cmp_vld_q <= issue;
          cmp_idx_q <= idx_q[AW-1:0];
          if (issue) begin
            idx_q <= idx_q + UW'(1);
          end
          if (hit_rep) begin
            pend_val_q <= rd_val_q;
            pend_vld_q <= 1'b1;
            if (pend_vld_q) begin
              // Second qualifier found: the first goes out now, the second
              // is the final result of the set.
              res_vld_q <= 1'b1;
              res_q     <= '{value_res: pend_val_q, is_last: 1'b0,
                             none_found: 1'b0, overflow: ovf_q};
              state_q   <= ST_FLUSH;
            end
          end else if (scan_end) begin
            res_vld_q <= 1'b1;
            if (pend_vld_q) begin
              res_q <= '{value_res: pend_val_q, is_last: 1'b1,
                         none_found: 1'b0, overflow: ovf_q};
            end else begin
              res_q <= '{value_res: '0, is_last: 1'b1,
                         none_found: 1'b1, overflow: ovf_q};
            end
            used_q  <= '0;
            total_q <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end

        ST_FLUSH: begin
          res_vld_q <= 1'b1;
          res_q     <= '{value_res: pend_val_q, is_last: 1'b1,
                         none_found: 1'b0, overflow: ovf_q};
          used_q    <= '0;
          total_q   <= '0;
          ovf_q     <= 1'b0;
          state_q   <= ST_IDLE;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_ENTRIES))
    else $error("distinct table count beyond table size");

  a_none_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.none_found) |-> (res_q.is_last && (res_q.value_res == '0)))
    else $error("none-found result not final or value not zero");

  a_flush_emits_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |=> (res_vld_q && res_q.is_last && !res_q.none_found))
    else $error("second qualifier not delivered as final result");

  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.is_last) |-> ((used_q == '0) && (total_q == '0) && !ovf_q))
    else $error("set state not cleared after final result");

endmodule
